@@ rtl/dhc_pkg.sv @@
// Shared types and constants of the debug halt controller.
`default_nettype none
package dhc_pkg;

   typedef enum logic [2:0] {
      FUNC_CHECK     = 3'd0,
      FUNC_STEP      = 3'd1,
      FUNC_STEP_OVER = 3'd2,
      FUNC_STEP_OUT  = 3'd3,
      FUNC_CONTINUE  = 3'd4,
      FUNC_BP_ADD    = 3'd5,
      FUNC_BP_REMOVE = 3'd6,
      FUNC_RESET     = 3'd7
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_OUT_RANGE  = 2'd1,
      STATUS_NOT_FOUND  = 2'd2,
      STATUS_TABLE_FULL = 2'd3
   } status_type;

   localparam int unsigned PROG_LEN_BITS = 17;
   localparam logic [PROG_LEN_BITS-1:0] PROG_LEN_RESET = 17'h10000;

   // Update request from the control logic to the breakpoint table.
   typedef struct packed {
      logic add;
      logic remove;
      logic clear;
   } bp_req_type;

   // Lookup result of the breakpoint table for the current key.
   typedef struct packed {
      logic match;
      logic full;
   } bp_stat_type;

endpackage
`default_nettype wire

@@ rtl/dhc_bp_table.sv @@
// Breakpoint table: parallel address match, lowest free entry insert, remove and clear.
`default_nettype none
module dhc_bp_table #(
   parameter int unsigned BP_ENTRIES = 16,
   parameter int unsigned ADDR_BITS  = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [ADDR_BITS-1:0] key,
   input  wire dhc_pkg::bp_req_type  req,
   output dhc_pkg::bp_stat_type      stat
);
   import dhc_pkg::*;

   logic [BP_ENTRIES-1:0] valid_ff;
   logic [BP_ENTRIES-1:0] valid_in;
   logic [ADDR_BITS-1:0]  addr_ff [BP_ENTRIES];
   logic [BP_ENTRIES-1:0] match_vec;
   logic [BP_ENTRIES-1:0] free_vec;
   logic [BP_ENTRIES-1:0] free_first;

   always_comb begin
      for (int i = 0; i < BP_ENTRIES; i++) begin
         match_vec[i] = valid_ff[i] && (addr_ff[i] == key);
      end
   end

   assign free_vec   = ~valid_ff;
   assign free_first = free_vec & (~free_vec + BP_ENTRIES'(1'b1));

   assign stat.match = |match_vec;
   assign stat.full  = &valid_ff;

   always_comb begin
      valid_in = valid_ff;
      if (req.clear) begin
         valid_in = '0;
      end else if (req.add) begin
         valid_in = valid_ff | free_first;
      end else if (req.remove) begin
         valid_in = valid_ff & ~match_vec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < BP_ENTRIES; i++) begin
         if (req.add && !req.clear && free_first[i]) begin
            addr_ff[i] <= key;
         end
      end
   end

`ifndef NO_ASSERTIONS
   a_one_match: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match_vec))
      else $error("breakpoint address held in more than one entry");
   a_add_sets_match: assert property (@(posedge clock) disable iff (reset)
      req.add && !req.clear |=> $countones(valid_ff) == $countones($past(valid_ff)) + 1)
      else $error("insert did not fill exactly one entry");
   a_remove_frees: assert property (@(posedge clock) disable iff (reset)
      req.remove && !req.add && !req.clear && stat.match
      |=> $countones(valid_ff) + 1 == $countones($past(valid_ff)))
      else $error("remove did not free exactly one entry");
`endif

endmodule
`default_nettype wire

@@ rtl/debug_halt_controller_top.sv @@
// Top level of the debug halt controller: input register, halt and command logic, result register.
`default_nettype none
// One item per clock: an item taken on start is registered, evaluated against the
// breakpoint table and the stepping state in the following cycle, and its single result
// appears on the rsp_ ports with rsp_valid from the result register. busy is always low, so
// start may be held high every cycle; the result strobe lasts one cycle and cannot be stalled.
// Breakpoint matching is a parallel compare over all entries. The user must write program_length
// through csr_write_enable and csr_write_data while idle; the block does not enforce this.
module debug_halt_controller_top #(
   parameter int unsigned BP_ENTRIES = 16,
   parameter int unsigned ADDR_BITS  = 16,
   parameter int unsigned DEPTH_BITS = 8
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output      logic                         busy,
   input  wire logic [2:0]                   req_func,
   input  wire logic [ADDR_BITS-1:0]         req_address,
   input  wire logic [DEPTH_BITS-1:0]        req_call_depth,
   output      logic                         rsp_valid,
   output      logic                         rsp_halt,
   output      logic                         rsp_breakpoint_hit,
   output      logic                         rsp_resume,
   output      logic [1:0]                   rsp_status,
   input  wire logic                         csr_write_enable,
   input  wire logic [dhc_pkg::PROG_LEN_BITS-1:0] csr_write_data
);
   import dhc_pkg::*;

   localparam int unsigned CMP_BITS = (ADDR_BITS > PROG_LEN_BITS) ? ADDR_BITS : PROG_LEN_BITS;

   logic                     req_valid_ff;
   func_type                 func_ff;
   logic [ADDR_BITS-1:0]     addr_ff;
   logic [DEPTH_BITS-1:0]    depth_ff;

   logic [PROG_LEN_BITS-1:0] prog_len_ff;
   logic                     over_armed_ff, over_armed_in;
   logic [DEPTH_BITS-1:0]    over_level_ff, over_level_in;
   logic                     out_armed_ff, out_armed_in;
   logic [DEPTH_BITS-1:0]    out_level_ff, out_level_in;
   logic                     run_free_ff, run_free_in;

   logic                     rsp_valid_ff;
   logic                     halt_ff, halt_in;
   logic                     hit_ff, hit_in;
   logic                     resume_ff, resume_in;
   status_type               status_ff, status_in;

   bp_req_type               bp_req;
   bp_stat_type              bp_stat;
   logic                     out_of_range;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         func_ff  <= func_type'(req_func);
         addr_ff  <= req_address;
         depth_ff <= req_call_depth;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prog_len_ff <= PROG_LEN_RESET;
      end else if (csr_write_enable) begin
         prog_len_ff <= csr_write_data;
      end
   end

   dhc_bp_table #(
      .BP_ENTRIES (BP_ENTRIES),
      .ADDR_BITS  (ADDR_BITS)
   ) u_bp_table (
      .clock (clock),
      .reset (reset),
      .key   (addr_ff),
      .req   (bp_req),
      .stat  (bp_stat)
   );

   assign out_of_range = CMP_BITS'(addr_ff) >= CMP_BITS'(prog_len_ff);

   always_comb begin
      bp_req.add    = req_valid_ff && (func_ff == FUNC_BP_ADD) && !out_of_range
                      && !bp_stat.match && !bp_stat.full;
      bp_req.remove = req_valid_ff && (func_ff == FUNC_BP_REMOVE);
      bp_req.clear  = req_valid_ff && (func_ff == FUNC_RESET);
   end

   always_comb begin
      over_armed_in = over_armed_ff;
      over_level_in = over_level_ff;
      out_armed_in  = out_armed_ff;
      out_level_in  = out_level_ff;
      run_free_in   = run_free_ff;
      halt_in       = 1'b0;
      hit_in        = 1'b0;
      resume_in     = func_ff inside {FUNC_STEP, FUNC_STEP_OVER, FUNC_STEP_OUT, FUNC_CONTINUE};
      status_in     = STATUS_OK;
      case (func_ff)
         FUNC_CHECK: begin
            if (bp_stat.match) begin
               halt_in = 1'b1;
               hit_in  = 1'b1;
            end else if (over_armed_ff && (depth_ff <= over_level_ff)) begin
               over_armed_in = 1'b0;
               halt_in       = 1'b1;
            end else if (out_armed_ff && (depth_ff < out_level_ff)) begin
               out_armed_in = 1'b0;
               halt_in      = 1'b1;
            end else if (!run_free_ff) begin
               halt_in = 1'b1;
            end
         end
         FUNC_STEP: begin
            over_armed_in = 1'b0;
            out_armed_in  = 1'b0;
            run_free_in   = 1'b0;
         end
         FUNC_STEP_OVER: begin
            over_armed_in = 1'b1;
            over_level_in = depth_ff;
            run_free_in   = 1'b1;
         end
         FUNC_STEP_OUT: begin
            out_armed_in = 1'b1;
            out_level_in = depth_ff;
            run_free_in  = 1'b1;
         end
         FUNC_CONTINUE: begin
            over_armed_in = 1'b0;
            out_armed_in  = 1'b0;
            run_free_in   = 1'b1;
         end
         FUNC_BP_ADD: begin
            if (out_of_range) begin
               status_in = STATUS_OUT_RANGE;
            end else if (!bp_stat.match && bp_stat.full) begin
               status_in = STATUS_TABLE_FULL;
            end
         end
         FUNC_BP_REMOVE: begin
            if (!bp_stat.match) begin
               status_in = STATUS_NOT_FOUND;
            end
         end
         FUNC_RESET: begin
            over_armed_in = 1'b0;
            out_armed_in  = 1'b0;
            run_free_in   = 1'b0;
         end
         default: begin
            halt_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         over_armed_ff <= 1'b0;
         over_level_ff <= '0;
         out_armed_ff  <= 1'b0;
         out_level_ff  <= '0;
         run_free_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (req_valid_ff) begin
            over_armed_ff <= over_armed_in;
            over_level_ff <= over_level_in;
            out_armed_ff  <= out_armed_in;
            out_level_ff  <= out_level_in;
            run_free_ff   <= run_free_in;
         end
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      halt_ff   <= halt_in;
      hit_ff    <= hit_in;
      resume_ff <= resume_in;
      status_ff <= status_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_halt           = halt_ff;
   assign rsp_breakpoint_hit = hit_ff;
   assign rsp_resume         = resume_ff;
   assign rsp_status         = status_ff;

`ifndef NO_ASSERTIONS
   a_hit_halts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_breakpoint_hit |-> rsp_halt)
      else $error("breakpoint hit without halt");
   a_halt_no_resume: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_halt && rsp_resume))
      else $error("halt and resume together");
   a_error_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_OK) |-> !rsp_halt && !rsp_resume)
      else $error("error status on a check or resume command");
   a_item_answers: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff |=> rsp_valid)
      else $error("item gave no result");
   a_over_arms: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && (func_ff == FUNC_STEP_OVER) |=> over_armed_ff && run_free_ff)
      else $error("step over did not arm");
`endif

endmodule
`default_nettype wire
